// File: src/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared constants, opcodes, region codes and the sideband type that travels
// alongside the divider pipeline.
// ----------------------------------------------------------------------------
package pli_pkg;

   // Default sizes for the top-level parameters.
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int VALUE_BITS_DEF  = 32;

   // Fixed field widths.
   localparam int XW        = 32;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int PT_IDX_W  = 4;
   localparam int SEG_W     = 4;
   localparam int REGION_W  = 2;
   localparam int CNT_W     = 5;

   // Quotient width and the number of restoring division steps.
   localparam int QW        = 32;
   localparam int DIV_STEPS = QW;

   // Opcodes of an input transaction.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE   = 1'b1;

   // Interpolation rules.
   localparam logic RULE_STANDARD = 1'b0;
   localparam logic RULE_UPPER    = 1'b1;

   // Region codes of a result.
   localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

   // Per-item information carried next to the division.
   typedef struct packed {
      logic [REGION_W-1:0] region;
      logic [SEG_W-1:0]    segment;
      logic                neg;
      logic signed [XW-1:0] base;
   } pli_side_type;

endpackage

// File: src/pli_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per stage.
// The dividend's upper half must be below the divisor.
// ----------------------------------------------------------------------------
module pli_divider
   import pli_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*QW-1:0]     in_dividend,
   input  logic [QW-1:0]       in_divisor,
   input  pli_side_type        in_side,
   output logic                out_valid,
   output logic [QW-1:0]       out_quotient,
   output pli_side_type        out_side
);

   logic [DIV_STEPS:0] valid_ff;
   logic [QW-1:0]      rem_ff  [0:DIV_STEPS];
   logic [QW-1:0]      low_ff  [0:DIV_STEPS];
   logic [QW-1:0]      quot_ff [0:DIV_STEPS];
   logic [QW-1:0]      dvs_ff  [0:DIV_STEPS];
   pli_side_type       side_ff [0:DIV_STEPS];

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIV_STEPS-1:0], in_valid};
      end
   end

   // Entry stage splits the dividend into partial remainder and pending bits.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= in_dividend[2*QW-1:QW];
      low_ff[0]  <= in_dividend[QW-1:0];
      quot_ff[0] <= '0;
      dvs_ff[0]  <= in_divisor;
      side_ff[0] <= in_side;
   end

   // One trial subtraction per stage.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [QW:0]   trial_in;
      logic [QW:0]   diff_in;
      logic [QW-1:0] rem_in;
      logic          qbit_in;

      always_comb begin
         trial_in = {rem_ff[j], low_ff[j][QW-1]};
         diff_in  = trial_in - {1'b0, dvs_ff[j]};
         qbit_in  = ~diff_in[QW];
         rem_in   = qbit_in ? diff_in[QW-1:0] : trial_in[QW-1:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[j+1]  <= rem_in;
         low_ff[j+1]  <= {low_ff[j][QW-2:0], 1'b0};
         quot_ff[j+1] <= {quot_ff[j][QW-2:0], qbit_in};
         dvs_ff[j+1]  <= dvs_ff[j];
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign out_valid    = valid_ff[DIV_STEPS];
   assign out_quotient = quot_ff[DIV_STEPS];
   assign out_side     = side_ff[DIV_STEPS];

endmodule

// File: src/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with segment search, rounded interpolation and saturation.
// ----------------------------------------------------------------------------
// A query passes the compare, table-read, numerator and product stages, the
// divider's entry stage and its 32 steps, and the output register to its strobe.
// Throughput: one transaction per cycle; busy stays low, the pipeline is
// fully stage-per-cycle with the 32-step divider as its longest section.
// Load transactions give no result and take effect at their acceptance.
// Reset clears the valid bits and the registers (points_in_use 2, rule 0);
// the breakpoint table is undefined until loaded.
module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic [PT_IDX_W-1:0]    req_point_index,
   input  logic signed [XW-1:0]   req_point_x,
   input  logic signed [XW-1:0]   req_point_y,
   input  logic signed [XW-1:0]   req_query_x,
   output logic                   rsp_strobe,
   output logic signed [XW-1:0]   rsp_value,
   output logic [SEG_W-1:0]       rsp_segment,
   output logic [REGION_W-1:0]    rsp_region,
   output logic                   rsp_saturated,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int NW0    = $clog2(TABLE_DEPTH + 1);
   localparam int NW     = (NW0 > CNT_W) ? NW0 : CNT_W;
   localparam int SUM_W  = XW + 2;
   localparam int CLIP_W = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;
   localparam logic signed [CLIP_W-1:0] SAT_HI =
      CLIP_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam logic signed [CLIP_W-1:0] SAT_LO = -SAT_HI - CLIP_W'(1);
   localparam int LATENCY = DIV_STEPS + 6;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Configuration registers.
   logic [CNT_W-1:0] points_ff;
   logic             rule_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= CNT_W'(2);
         rule_ff   <= RULE_STANDARD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POINTS: points_ff <= csr_data;
            CSR_RULE:   rule_ff   <= csr_data[0];
            default:    ;
         endcase
      end
   end

   // Breakpoint table, written by load transactions at acceptance.
   logic signed [XW-1:0] x_ff [0:TABLE_DEPTH-1];
   logic signed [XW-1:0] y_ff [0:TABLE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_LOAD && int'(req_point_index) < TABLE_DEPTH) begin
         x_ff[AW'(req_point_index)] <= req_point_x;
         y_ff[AW'(req_point_index)] <= req_point_y;
      end
   end

   // Stage 1: compare the query against every breakpoint.
   logic                   s1_valid_ff;
   logic signed [XW-1:0]   s1_q_ff;
   logic [TABLE_DEPTH-1:0] s1_lt_ff;
   logic [TABLE_DEPTH-1:0] s1_le_ff;
   logic [TABLE_DEPTH-1:0] lt_in;
   logic [TABLE_DEPTH-1:0] le_in;

   always_comb begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         lt_in[k] = x_ff[k] < req_query_x;
         le_in[k] = x_ff[k] <= req_query_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && req_opcode == OP_QUERY;
      end
   end

   always_ff @(posedge clock) begin
      s1_q_ff  <= req_query_x;
      s1_lt_ff <= lt_in;
      s1_le_ff <= le_in;
   end

   // Stage 1 logic: region, segment and the two table addresses.
   logic [NW-1:0]       n_in;
   logic [AW-1:0]       last_in;
   logic [AW-1:0]       hit_in;
   logic [AW-1:0]       lo_addr_in;
   logic [AW-1:0]       hi_addr_in;
   logic [REGION_W-1:0] region_in;

   always_comb begin
      if (NW'(points_ff) < NW'(2)) begin
         n_in = NW'(2);
      end else if (NW'(points_ff) > NW'(TABLE_DEPTH)) begin
         n_in = NW'(TABLE_DEPTH);
      end else begin
         n_in = NW'(points_ff);
      end
      last_in = AW'(n_in - NW'(1));
      hit_in  = last_in;
      for (int k = TABLE_DEPTH - 1; k >= 1; k--) begin
         if (AW'(k) < last_in && !s1_lt_ff[k]) begin
            hit_in = AW'(k);
         end
      end
      priority if (!s1_lt_ff[0]) begin
         region_in  = REGION_BELOW;
         lo_addr_in = '0;
         hi_addr_in = AW'(1);
      end else if (s1_le_ff[last_in]) begin
         region_in  = REGION_ABOVE;
         lo_addr_in = last_in - AW'(1);
         hi_addr_in = last_in;
      end else begin
         region_in  = REGION_INTERP;
         lo_addr_in = hit_in - AW'(1);
         hi_addr_in = hit_in;
      end
   end

   // Stage 2: registered table reads at the segment ends.
   logic                 s2_valid_ff;
   logic signed [XW-1:0] s2_q_ff;
   logic signed [XW-1:0] s2_xa_ff;
   logic signed [XW-1:0] s2_xb_ff;
   logic signed [XW-1:0] s2_ya_ff;
   logic signed [XW-1:0] s2_yb_ff;
   logic [REGION_W-1:0]  s2_region_ff;
   logic [SEG_W-1:0]     s2_seg_ff;
   logic                 s2_rule_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_q_ff      <= s1_q_ff;
      s2_xa_ff     <= x_ff[lo_addr_in];
      s2_xb_ff     <= x_ff[hi_addr_in];
      s2_ya_ff     <= y_ff[lo_addr_in];
      s2_yb_ff     <= y_ff[hi_addr_in];
      s2_region_ff <= region_in;
      s2_seg_ff    <= (region_in == REGION_BELOW) ? '0 : SEG_W'(hi_addr_in);
      s2_rule_ff   <= rule_ff;
   end

   // Stage 3: segment width, offset and the signed numerator's magnitude.
   logic signed [XW:0] dx_in;
   logic signed [XW:0] off_in;
   logic signed [XW:0] num_in;
   logic signed [XW:0] mag_in;
   pli_side_type       side3_in;

   always_comb begin
      dx_in  = {s2_xb_ff[XW-1], s2_xb_ff} - {s2_xa_ff[XW-1], s2_xa_ff};
      off_in = {s2_q_ff[XW-1], s2_q_ff} - {s2_xa_ff[XW-1], s2_xa_ff};
      if (s2_rule_ff == RULE_UPPER) begin
         num_in = {s2_yb_ff[XW-1], s2_yb_ff};
      end else begin
         num_in = {s2_yb_ff[XW-1], s2_yb_ff} - {s2_ya_ff[XW-1], s2_ya_ff};
      end
      mag_in           = num_in[XW] ? -num_in : num_in;
      side3_in.region  = s2_region_ff;
      side3_in.segment = s2_seg_ff;
      side3_in.neg     = num_in[XW];
      side3_in.base    = (s2_region_ff == REGION_ABOVE) ? s2_yb_ff : s2_ya_ff;
   end

   logic          s3_valid_ff;
   logic [QW-1:0] s3_mag_ff;
   logic [QW-1:0] s3_off_ff;
   logic [QW-1:0] s3_dx_ff;
   pli_side_type  s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_mag_ff  <= (s2_region_ff == REGION_INTERP) ? mag_in[QW-1:0] : '0;
      s3_off_ff  <= off_in[QW-1:0];
      s3_dx_ff   <= dx_in[QW-1:0];
      s3_side_ff <= side3_in;
   end

   // Stage 4: exact product of magnitude and offset.
   logic            s4_valid_ff;
   logic [2*QW-1:0] s4_prod_ff;
   logic [QW-1:0]   s4_dx_ff;
   pli_side_type    s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_prod_ff <= s3_mag_ff * s3_off_ff;
      s4_dx_ff   <= s3_dx_ff;
      s4_side_ff <= s3_side_ff;
   end

   // Round to nearest by adding half the divisor, then divide.
   logic [2*QW-1:0] dividend_in;
   logic            div_valid;
   logic [QW-1:0]   div_quot;
   pli_side_type    div_side;

   assign dividend_in = s4_prod_ff + {{QW{1'b0}}, 1'b0, s4_dx_ff[QW-1:1]};

   pli_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s4_valid_ff),
      .in_dividend  (dividend_in),
      .in_divisor   (s4_dx_ff),
      .in_side      (s4_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quot),
      .out_side     (div_side)
   );

   // Final stage: apply the sign, add the base and saturate.
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [CLIP_W-1:0] wide_in;
   logic signed [CLIP_W-1:0] clip_in;
   logic                     sat_in;

   always_comb begin
      if (div_side.region == REGION_INTERP) begin
         if (div_side.neg) begin
            sum_in = SUM_W'(div_side.base) - SUM_W'({1'b0, div_quot});
         end else begin
            sum_in = SUM_W'(div_side.base) + SUM_W'({1'b0, div_quot});
         end
      end else begin
         sum_in = SUM_W'(div_side.base);
      end
      wide_in = CLIP_W'(sum_in);
      priority if (wide_in > SAT_HI) begin
         clip_in = SAT_HI;
         sat_in  = 1'b1;
      end else if (wide_in < SAT_LO) begin
         clip_in = SAT_LO;
         sat_in  = 1'b1;
      end else begin
         clip_in = wide_in;
         sat_in  = 1'b0;
      end
   end

   logic                 out_valid_ff;
   logic signed [XW-1:0] out_value_ff;
   logic [SEG_W-1:0]     out_seg_ff;
   logic [REGION_W-1:0]  out_region_ff;
   logic                 out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= clip_in[XW-1:0];
      out_seg_ff    <= div_side.segment;
      out_region_ff <= div_side.region;
      out_sat_ff    <= sat_in;
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_segment   = out_seg_ff;
   assign rsp_region    = out_region_ff;
   assign rsp_saturated = out_sat_ff;

   // Every accepted query yields its result after the fixed latency.
   a_query_result : assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_QUERY) |-> ##LATENCY rsp_strobe)
      else $error("query transaction produced no result");

   // A load transaction never produces a result.
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_LOAD) |-> ##LATENCY !rsp_strobe)
      else $error("load transaction produced a result");

   // Clamped below always reports the first breakpoint.
   a_below_segment : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_region == REGION_BELOW) |-> rsp_segment == '0)
      else $error("clamped-below result with nonzero segment");

   // An interpolated result never uses segment zero.
   a_interp_segment : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_region == REGION_INTERP) |-> rsp_segment != '0)
      else $error("interpolated result on segment zero");

endmodule
